>>> hw/rtl/tkst_pkg.sv
package tkst_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam int ENTRY_COUNT_W = 7;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] tag;
        logic [31:0]        handle;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [31:0]              handle_out;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_resp;

    typedef struct packed {
        logic        used;
        logic [31:0] key;
        logic [31:0] value;
    } t_slot;

endpackage

>>> hw/rtl/tkst_ram.sv
module tkst_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/tag_keyed_slot_table_top.sv
// A direct lookup or insert passes from S_IDLE through S_DCHK to S_RESP, which raises the registered response valid.
// A scan examines one slot per cycle; the worst insert scans up to twice the slot count.
// Only one request is in progress at a time: a request is taken only in the idle state.
// Reset is synchronous; afterwards a clearing pass writes every slot in turn, with no request taken.
// A clear-all request sweeps the memory the same way after its response is issued.
module tag_keyed_slot_table_top #(
    parameter int SLOT_COUNT = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  tkst_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output tkst_pkg::t_resp o_resp
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int FW = AW + 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DCHK  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        M_FIND  = 2'd0,
        M_FREE  = 2'd1,
        M_LOWER = 2'd2
    } t_mode;

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    tkst_pkg::t_op     r_op, n_op;
    logic [31:0]       r_tag, n_tag;
    logic [31:0]       r_handle, n_handle;
    logic [FW-1:0]     r_idx, n_idx;
    logic              r_more, n_more;
    logic              r_chk_vld, n_chk_vld;
    logic [AW-1:0]     r_chk_idx, n_chk_idx;
    logic              r_dfree, n_dfree;
    logic [CW-1:0]     r_occ, n_occ;
    logic [AW-1:0]     r_hu, n_hu;
    logic [FW-1:0]     r_fss, n_fss;
    logic              r_all_direct, n_all_direct;
    tkst_pkg::t_status r_status, n_status;
    logic [31:0]       r_hout, n_hout;
    tkst_pkg::t_resp   r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    tkst_pkg::t_slot           wr_data;
    logic [AW-1:0]             rd_addr;
    logic [$bits(tkst_pkg::t_slot)-1:0] rd_raw;
    tkst_pkg::t_slot           rd_slot;

    logic          find_done, find_hit;
    logic [AW-1:0] find_idx;
    logic          scan_match, scan_hit, scan_end, dfree_now, in_range;

    tkst_ram #(
        .WIDTH($bits(tkst_pkg::t_slot)),
        .DEPTH(SLOT_COUNT)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_slot  = tkst_pkg::t_slot'(rd_raw);
    assign in_range = $unsigned(i_req.tag) < 32'(SLOT_COUNT);

    always_comb begin
        case (r_mode)
            M_FIND:  scan_match = rd_slot.used && (rd_slot.key == r_tag);
            M_FREE:  scan_match = !rd_slot.used;
            M_LOWER: scan_match = rd_slot.used;
            default: scan_match = 1'b0;
        endcase
    end

    assign scan_hit  = r_chk_vld && scan_match;
    assign scan_end  = !r_more && !scan_hit;
    assign dfree_now = (r_state == S_DCHK) ? !rd_slot.used : r_dfree;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_op         = r_op;
        n_tag        = r_tag;
        n_handle     = r_handle;
        n_idx        = r_idx;
        n_more       = r_more;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_dfree      = r_dfree;
        n_occ        = r_occ;
        n_hu         = r_hu;
        n_fss        = r_fss;
        n_all_direct = r_all_direct;
        n_status     = r_status;
        n_hout       = r_hout;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        wr_en        = 1'b0;
        wr_addr      = r_idx[AW-1:0];
        wr_data      = '0;
        rd_addr      = r_idx[AW-1:0];
        find_done    = 1'b0;
        find_hit     = 1'b0;
        find_idx     = r_tag[AW-1:0];

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                if (r_idx == FW'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                rd_addr = i_req.tag[AW-1:0];
                if (i_req_valid) begin
                    n_op     = i_req.op;
                    n_tag    = $unsigned(i_req.tag);
                    n_handle = i_req.handle;
                    n_status = tkst_pkg::ST_OK;
                    n_hout   = '0;
                    if (i_req.op == tkst_pkg::OP_CLEAR) begin
                        n_occ        = '0;
                        n_hu         = '0;
                        n_fss        = '0;
                        n_all_direct = 1'b1;
                        n_idx        = '0;
                        n_state      = S_RESP;
                    end else if (in_range) begin
                        n_state = S_DCHK;
                    end else begin
                        n_dfree   = 1'b0;
                        n_mode    = M_FIND;
                        n_idx     = '0;
                        n_more    = 1'b1;
                        n_chk_vld = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_DCHK: begin
                n_dfree = !rd_slot.used;
                if (r_all_direct) begin
                    find_done = 1'b1;
                    find_hit  = rd_slot.used;
                end else if (rd_slot.used && (rd_slot.key == r_tag)) begin
                    find_done = 1'b1;
                    find_hit  = 1'b1;
                end else begin
                    n_mode    = M_FIND;
                    n_idx     = '0;
                    n_more    = 1'b1;
                    n_chk_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                n_chk_vld = r_more;
                n_chk_idx = r_idx[AW-1:0];
                if (r_more) begin
                    case (r_mode)
                        M_FIND: begin
                            n_more = r_idx[AW-1:0] != r_hu;
                            n_idx  = r_idx + 1'b1;
                        end
                        M_FREE: begin
                            n_more = r_idx != FW'(SLOT_COUNT - 1);
                            n_idx  = r_idx + 1'b1;
                        end
                        default: begin
                            n_more = r_idx != '0;
                            n_idx  = r_idx - 1'b1;
                        end
                    endcase
                end
                case (r_mode)
                    M_FIND: begin
                        if (scan_hit || scan_end) begin
                            find_done = 1'b1;
                            find_hit  = scan_hit;
                            find_idx  = r_chk_idx;
                        end
                    end
                    M_FREE: begin
                        if (scan_hit) begin
                            wr_en         = 1'b1;
                            wr_addr       = r_chk_idx;
                            wr_data.used  = 1'b1;
                            wr_data.key   = r_tag;
                            wr_data.value = r_handle;
                            n_occ         = r_occ + 1'b1;
                            if (r_chk_idx > r_hu) begin
                                n_hu = r_chk_idx;
                            end
                            n_all_direct  = 1'b0;
                            n_fss         = {1'b0, r_chk_idx};
                            n_state       = S_RESP;
                        end else if (scan_end) begin
                            n_fss    = FW'(SLOT_COUNT);
                            n_status = tkst_pkg::ST_FULL;
                            n_state  = S_RESP;
                        end
                    end
                    default: begin
                        if (scan_hit) begin
                            n_hu    = r_chk_idx;
                            n_state = S_RESP;
                        end else if (scan_end) begin
                            n_state = S_RESP;
                        end
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out.status      = r_status;
                    n_out.handle_out  = r_hout;
                    n_out.entry_count = tkst_pkg::ENTRY_COUNT_W'(r_occ);
                    n_out_valid       = 1'b1;
                    n_state           = (r_op == tkst_pkg::OP_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (find_done) begin
            case (r_op)
                tkst_pkg::OP_INSERT: begin
                    if (find_hit) begin
                        n_status = tkst_pkg::ST_DUPLICATE;
                        n_state  = S_RESP;
                    end else if (r_occ >= CW'(SLOT_COUNT)) begin
                        n_status = tkst_pkg::ST_FULL;
                        n_state  = S_RESP;
                    end else if (dfree_now) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_tag[AW-1:0];
                        wr_data.used  = 1'b1;
                        wr_data.key   = r_tag;
                        wr_data.value = r_handle;
                        n_occ         = r_occ + 1'b1;
                        if (r_tag[AW-1:0] > r_hu) begin
                            n_hu = r_tag[AW-1:0];
                        end
                        n_state       = S_RESP;
                    end else begin
                        n_mode    = M_FREE;
                        n_idx     = r_fss;
                        n_more    = r_fss < FW'(SLOT_COUNT);
                        n_chk_vld = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
                tkst_pkg::OP_REMOVE, tkst_pkg::OP_LOOKUP: begin
                    if (!find_hit) begin
                        n_status = tkst_pkg::ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        n_hout  = rd_slot.value;
                        n_state = S_RESP;
                        if (r_op == tkst_pkg::OP_REMOVE) begin
                            wr_en   = 1'b1;
                            wr_addr = find_idx;
                            if (r_occ != '0) begin
                                n_occ = r_occ - 1'b1;
                            end
                            if (!r_all_direct) begin
                                n_fss = '0;
                            end
                            if ((r_hu == find_idx) && (find_idx != '0)) begin
                                n_mode    = M_LOWER;
                                n_idx     = {1'b0, find_idx} - 1'b1;
                                n_more    = 1'b1;
                                n_chk_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                    end
                end
                default: begin
                    n_state = S_RESP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_mode       <= M_FIND;
            r_idx        <= '0;
            r_more       <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_occ        <= '0;
            r_hu         <= '0;
            r_fss        <= '0;
            r_all_direct <= 1'b1;
            r_out_valid  <= 1'b0;
            r_op         <= tkst_pkg::OP_CLEAR;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_idx        <= n_idx;
            r_more       <= n_more;
            r_chk_vld    <= n_chk_vld;
            r_occ        <= n_occ;
            r_hu         <= n_hu;
            r_fss        <= n_fss;
            r_all_direct <= n_all_direct;
            r_out_valid  <= n_out_valid;
            r_op         <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_handle  <= n_handle;
        r_chk_idx <= n_chk_idx;
        r_dfree   <= n_dfree;
        r_status  <= n_status;
        r_hout    <= n_hout;
        r_out     <= n_out;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_resp      = r_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(SLOT_COUNT))
        else $error("occupied count exceeds the slot count");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fss <= FW'(SLOT_COUNT))
        else $error("free search hint beyond the table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while the previous one is in progress");

    a_free_scan_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_mode == M_FREE) |-> (r_op == tkst_pkg::OP_INSERT))
        else $error("free slot scan outside an insert");

    a_lower_scan_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_mode == M_LOWER) |-> (r_op == tkst_pkg::OP_REMOVE))
        else $error("highest slot search outside a remove");

endmodule
